FILE: hw/rtl/hhrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhrs_pkg
// Types and constants shared by the host heartbeat restart supervisor.
// ----------------------------------------------------------------------------
package hhrs_pkg;

	// Item operations.
	localparam logic OP_POLL   = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	// Packet commands and the rest-time code that leaves the timeout alone.
	localparam logic [7:0] CMD_RESTART = 8'h01;
	localparam logic [7:0] CMD_DEFAULT = 8'h02;
	localparam logic [7:0] REST_KEEP   = 8'hFF;

	// Largest timeout that a reply frame can carry.
	localparam logic [15:0] REPLY_MAX = 16'd254;

	// Configuration register indexes.
	localparam logic [1:0] REG_HOLD_SECONDS    = 2'd0;
	localparam logic [1:0] REG_DEFAULT_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_MIN_TIMEOUT     = 2'd2;

	// Configuration reset values.
	localparam logic [7:0]  HOLD_SECONDS_RST    = 8'd5;
	localparam logic [15:0] DEFAULT_TIMEOUT_RST = 16'd60;
	localparam logic [7:0]  MIN_TIMEOUT_RST     = 8'd5;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_TIMEOUT  = 3'd1,
		EV_COMMAND  = 3'd2,
		EV_RELEASED = 3'd3,
		EV_HANDLED  = 3'd4,
		EV_DROPPED  = 3'd5
	} event_t;

	typedef struct packed {
		logic        op;
		logic [31:0] now_sec;
		logic [7:0]  command;
		logic [7:0]  timeout_req;
	} item_t;

	typedef struct packed {
		logic       restart_line;
		logic       status_led;
		event_t     event_res;
		logic       reply_valid;
		logic [7:0] reply_timeout;
		logic [7:0] reply_command;
	} result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/host_heartbeat_restart_supervisor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// host_heartbeat_restart_supervisor
// Heartbeat watchdog that drives a host restart line from time polls and
// heartbeat packets, and reports each item's outcome as one result transfer.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    item_t   (op, now_sec, ...)
// result    out        result_valid / result_stall result_t (restart_line, ...)
// cfg       in         cfg_we                     cfg_index, cfg_data
//
// An item is taken into the input register on the edge of its transfer, and
// its result is written to the result register when the input register moves
// on, so one item can be taken in every cycle while the result side does not
// stall.
// The supervisor state is updated on the same edge as the result register,
// which lets the next item in the input register see it without a gap.
// A stall on the result side holds the result register and then the input
// register; item_stall rises only while the input register is occupied and
// cannot move on. Reset clears the control state and loads the register
// reset values; timeout_now starts at the default timeout.
//
module host_heartbeat_restart_supervisor
	import hhrs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire item_t       item,

	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result,

	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// Configuration registers.
	logic [7:0]  hold_seconds_q;
	logic [15:0] default_timeout_q;
	logic [7:0]  min_timeout_q;

	// Supervisor state.
	logic        holding_q;
	logic [31:0] last_heartbeat_q;
	logic [31:0] hold_start_q;
	logic [15:0] timeout_now_q;
	logic        line_q;
	logic        led_q;

	// Input register and result register.
	logic        valid_s1;
	item_t       item_s1;
	logic        result_valid_q;
	result_t     result_q;

	// Next-state values computed from the item in the input register.
	logic        holding_d;
	logic [31:0] last_heartbeat_d;
	logic [31:0] hold_start_d;
	logic [15:0] timeout_now_d;
	logic        line_d;
	logic        led_d;
	result_t     result_d;

	logic        advance;
	logic        take_item;
	logic [31:0] hold_elapsed;
	logic [31:0] silence;
	logic [7:0]  floored_rest;

	// The input register moves on when the result register is empty or its
	// transfer completes in this cycle.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take_item  = item_valid && !item_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Time differences wrap modulo two to the thirty-second.
	assign hold_elapsed = item_s1.now_sec - hold_start_q;
	assign silence      = item_s1.now_sec - last_heartbeat_q;
	assign floored_rest = (item_s1.timeout_req < min_timeout_q) ? min_timeout_q
	                                                            : item_s1.timeout_req;

	always_comb begin
		holding_d        = holding_q;
		last_heartbeat_d = last_heartbeat_q;
		hold_start_d     = hold_start_q;
		timeout_now_d    = timeout_now_q;
		line_d           = line_q;
		led_d            = led_q;
		result_d         = '0;
		result_d.event_res = EV_NONE;

		if (item_s1.op == OP_POLL) begin
			if (holding_q) begin
				// The first poll after the hold time releases the line.
				if (hold_elapsed >= {24'd0, hold_seconds_q}) begin
					line_d           = 1'b0;
					holding_d        = 1'b0;
					last_heartbeat_d = item_s1.now_sec;
					result_d.event_res = EV_RELEASED;
				end
			end else if (silence >= {16'd0, timeout_now_q}) begin
				line_d       = 1'b1;
				led_d        = 1'b1;
				hold_start_d = item_s1.now_sec;
				holding_d    = 1'b1;
				result_d.event_res = EV_TIMEOUT;
			end
		end else if (holding_q) begin
			result_d.event_res = EV_DROPPED;
		end else begin
			last_heartbeat_d = item_s1.now_sec;
			result_d.event_res = EV_HANDLED;
			led_d            = 1'b0;
			if (item_s1.command == CMD_DEFAULT) begin
				timeout_now_d = default_timeout_q;
			end else if (item_s1.command == CMD_RESTART) begin
				line_d       = 1'b1;
				led_d        = 1'b1;
				hold_start_d = item_s1.now_sec;
				holding_d    = 1'b1;
				result_d.event_res = EV_COMMAND;
			end
			// A timeout request overrides the default that command 2 loads.
			if (item_s1.timeout_req != REST_KEEP) begin
				timeout_now_d = {8'd0, floored_rest};
			end
			result_d.reply_valid   = 1'b1;
			result_d.reply_timeout = (timeout_now_d > REPLY_MAX) ? REPLY_MAX[7:0]
			                                                     : timeout_now_d[7:0];
			result_d.reply_command = item_s1.command;
		end

		result_d.restart_line = line_d;
		result_d.status_led   = led_d;
	end

	// Control state, configuration and supervisor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			result_valid_q    <= 1'b0;
			hold_seconds_q    <= HOLD_SECONDS_RST;
			default_timeout_q <= DEFAULT_TIMEOUT_RST;
			min_timeout_q     <= MIN_TIMEOUT_RST;
			holding_q         <= 1'b0;
			last_heartbeat_q  <= '0;
			hold_start_q      <= '0;
			timeout_now_q     <= DEFAULT_TIMEOUT_RST;
			line_q            <= 1'b0;
			led_q             <= 1'b0;
		end else begin
			if (take_item) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			if (advance) begin
				holding_q        <= holding_d;
				last_heartbeat_q <= last_heartbeat_d;
				hold_start_q     <= hold_start_d;
				timeout_now_q    <= timeout_now_d;
				line_q           <= line_d;
				led_q            <= led_d;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_HOLD_SECONDS:    hold_seconds_q    <= cfg_data[7:0];
					REG_DEFAULT_TIMEOUT: default_timeout_q <= cfg_data;
					REG_MIN_TIMEOUT:     min_timeout_q     <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take_item) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

	// A restart, by timeout or by command, always shows the line and LED high.
	a_restart_levels: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.event_res == EV_TIMEOUT ||
		                   result_q.event_res == EV_COMMAND)
		|-> result_q.restart_line && result_q.status_led)
		else $error("restart result without line and LED asserted");

	// A reply is due exactly for packets that were handled or carried a restart command.
	a_reply_events: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.reply_valid ==
		                    (result_q.event_res == EV_HANDLED ||
		                     result_q.event_res == EV_COMMAND)))
		else $error("reply_valid disagrees with the event");

	// Without a reply the reply fields are zero.
	a_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.reply_valid
		|-> result_q.reply_timeout == 8'd0 && result_q.reply_command == 8'd0)
		else $error("reply fields set without a reply");

	// The restart line is high exactly while a hold is running.
	a_line_holding: assert property (@(posedge clk) disable iff (!arst_n)
		line_q == holding_q)
		else $error("restart line out of step with the hold");

	// The input side stalls only behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid_q && result_stall)
		else $error("item stalled without a stalled result");

endmodule
`default_nettype wire
